>>> hw/rtl/pcm_pkg.sv
// Shared types and constants for the pump cycle monitor.
package pcm_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0]  MIN_TOGGLE_RST  = TimeW'(1000 * 5);
  localparam logic [TimeW-1:0]  MAX_QUIET_RST   = TimeW'(1000 * 20);
  localparam logic [TimeW-1:0]  TX_PERIOD_RST   = TimeW'(1000 * 2);
  localparam logic [CountW-1:0] COUNT_MAX       = {CountW{1'b1}};

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_OFF  = 2'd1,
    EV_ON   = 2'd2
  } pump_event_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_LOW_PRESSURE = 2'd1,
    ST_NO_ACTIVITY  = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_TOGGLE = 2'd0,
    REG_MAX_QUIET  = 2'd1,
    REG_TX_PERIOD  = 2'd2
  } cfg_reg_t;

endpackage

>>> hw/rtl/pump_cycle_monitor_top.sv
// Pump cycle monitor: edge reporting, short-cycle counting, quiet alert and transmit strobe.
//
// Each accepted transaction (a millisecond timestamp and a pump switch level) yields exactly one
// result transaction. A transaction is first captured in an input register, then evaluated by
// combinational compare and subtract logic against the monitor state and placed in the result
// register, so it sustains one transaction per cycle while the result side does not stall;
// the result is offered when the transaction enters the result register. The only thing that
// holds the input back is a result-side stall while the input and result registers are occupied.
// Configuration writes take effect at once and are intended only while the block is idle.
module pump_cycle_monitor_top
  import pcm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [TimeW-1:0]    cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [TimeW-1:0]    in_now_ms,
  input  logic                in_switch_level,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_pump_event,
  output logic                out_transmit_now,
  output logic [1:0]          out_status,
  output logic                out_alert_raised,
  output logic [CountW-1:0]   out_error_count
);

  // Configuration registers.
  logic [TimeW-1:0] min_toggle_r, max_quiet_r, tx_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_toggle_r <= MIN_TOGGLE_RST;
      max_quiet_r  <= MAX_QUIET_RST;
      tx_period_r  <= TX_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_TOGGLE: min_toggle_r <= cfg_data;
        REG_MAX_QUIET:  max_quiet_r  <= cfg_data;
        REG_TX_PERIOD:  tx_period_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic             stg_valid_r;
  logic [TimeW-1:0] stg_now_r;
  logic             stg_level_r;
  logic             advance;
  logic             in_accept;

  assign advance   = stg_valid_r && (!out_valid || !out_stall);
  assign in_stall  = stg_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_accept) begin
      stg_valid_r <= 1'b1;
    end else if (advance) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_now_r   <= in_now_ms;
      stg_level_r <= in_switch_level;
    end
  end

  // Monitor state.
  logic              running_r, running_nxt;
  logic [TimeW-1:0]  last_on_r, last_on_nxt;
  logic [TimeW-1:0]  last_send_r, last_send_nxt;
  logic [TimeW-1:0]  elapsed_r, elapsed_nxt;
  logic [CountW-1:0] short_cnt_r, short_cnt_nxt;
  status_t           status_r, status_nxt;
  logic              armed_r, armed_nxt;
  pump_event_t       event_nxt;
  logic              xmit_nxt;
  logic              alert_nxt;
  logic [TimeW-1:0]  since_send;

  always_comb begin
    running_nxt   = running_r;
    last_on_nxt   = last_on_r;
    last_send_nxt = last_send_r;
    short_cnt_nxt = short_cnt_r;
    status_nxt    = status_r;
    armed_nxt     = armed_r;
    event_nxt     = EV_NONE;
    xmit_nxt      = 1'b0;
    alert_nxt     = 1'b0;

    if (running_r) begin
      if (!stg_level_r) begin
        running_nxt = 1'b0;
        event_nxt   = EV_OFF;
      end
    end else if (stg_level_r) begin
      running_nxt = 1'b1;
      last_on_nxt = stg_now_r;
      event_nxt   = EV_ON;
      // The gap tested is the one latched at the previous transaction.
      if (elapsed_r < min_toggle_r) begin
        if (short_cnt_r != COUNT_MAX) begin
          short_cnt_nxt = short_cnt_r + CountW'(1);
        end
        if (short_cnt_nxt >= CountW'(2)) begin
          status_nxt = ST_LOW_PRESSURE;
        end
      end else begin
        status_nxt    = ST_OK;
        short_cnt_nxt = '0;
      end
    end

    elapsed_nxt = stg_now_r - last_on_nxt;

    if (elapsed_nxt > max_quiet_r) begin
      if (armed_r) begin
        armed_nxt  = 1'b0;
        status_nxt = ST_NO_ACTIVITY;
        alert_nxt  = 1'b1;
      end
    end else begin
      armed_nxt = 1'b1;
    end

    since_send = stg_now_r - last_send_r;
    if (since_send >= tx_period_r) begin
      last_send_nxt = stg_now_r;
      xmit_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      last_on_r   <= '0;
      last_send_r <= '0;
      elapsed_r   <= '0;
      short_cnt_r <= '0;
      status_r    <= ST_NO_ACTIVITY;
      armed_r     <= 1'b1;
    end else if (advance) begin
      running_r   <= running_nxt;
      last_on_r   <= last_on_nxt;
      last_send_r <= last_send_nxt;
      elapsed_r   <= elapsed_nxt;
      short_cnt_r <= short_cnt_nxt;
      status_r    <= status_nxt;
      armed_r     <= armed_nxt;
    end
  end

  // Result register.
  logic              out_valid_r;
  pump_event_t       out_event_r;
  logic              out_xmit_r;
  status_t           out_status_r;
  logic              out_alert_r;
  logic [CountW-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r  <= event_nxt;
      out_xmit_r   <= xmit_nxt;
      out_status_r <= status_nxt;
      out_alert_r  <= alert_nxt;
      out_count_r  <= short_cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pump_event   = out_event_r;
  assign out_transmit_now = out_xmit_r;
  assign out_status       = out_status_r;
  assign out_alert_raised = out_alert_r;
  assign out_error_count  = out_count_r;

  // A turn-on edge is never reported while the pump is already running.
  a_no_double_on: assert property (@(posedge clk) disable iff (!rst_n)
    advance && running_r |-> event_nxt != EV_ON)
    else $error("turn-on reported while pump already running");

  // A raised alert always comes with no-activity status.
  a_alert_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alert_raised |-> out_status == ST_NO_ACTIVITY)
    else $error("alert raised without no-activity status");

  // Firing the alert disarms it.
  a_alert_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    advance && alert_nxt |=> !armed_r)
    else $error("alert fired but remained armed");

  // A saturated count either holds or is cleared, never wraps.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    short_cnt_r == COUNT_MAX |=> short_cnt_r == COUNT_MAX || short_cnt_r == '0)
    else $error("short cycle count wrapped");

  // The state only changes when a transaction moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(last_on_r) && $stable(elapsed_r))
    else $error("monitor state changed without a transaction");

endmodule
